FILE: src/cme_pkg.sv
// ----------------------------------------------------------------------------
// cme_pkg
// Shared types, constants and the letter pattern table for the Morse encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cme_pkg;

  // output symbol codes
  typedef enum logic [1:0] {
    SYM_DOT   = 2'd0,
    SYM_DASH  = 2'd1,
    SYM_SPACE = 2'd2,
    SYM_SLASH = 2'd3
  } symbol_t;

  // most symbols one character can cause
  localparam int MAX_SYMS        = 6;
  localparam int CNT_W           = $clog2(MAX_SYMS + 1);
  localparam int SYMS_W          = 2 * MAX_SYMS;
  localparam int PAT_MAX         = 5;
  localparam int FIFO_DEPTH_DEF  = 2;

  // character codes
  localparam logic [15:0] CH_SPACE     = 16'h0020;
  localparam logic [15:0] CH_YO_UPPER  = 16'h0401;
  localparam logic [15:0] CH_YO_LOWER  = 16'h0451;
  localparam logic [15:0] CH_LETTER_LO = 16'h0410;
  localparam logic [15:0] CH_LETTER_HI = 16'h044F;

  // one queued request: symbols in order from the low bits, and their number
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [SYMS_W-1:0] syms;
  } job_t;

  // letter pattern: length and one bit per symbol, set for a dash
  typedef struct packed {
    logic [2:0]         len;
    logic [PAT_MAX-1:0] dashes;
  } pattern_t;

  // patterns for U+0410..U+042F, bit 0 is the first symbol
  function automatic pattern_t letter_pattern(input logic [4:0] idx);
    pattern_t p;
    case (idx)
      5'd0:    p = '{len: 3'd2, dashes: 5'b00010};
      5'd1:    p = '{len: 3'd4, dashes: 5'b00001};
      5'd2:    p = '{len: 3'd3, dashes: 5'b00110};
      5'd3:    p = '{len: 3'd3, dashes: 5'b00011};
      5'd4:    p = '{len: 3'd3, dashes: 5'b00001};
      5'd5:    p = '{len: 3'd1, dashes: 5'b00000};
      5'd6:    p = '{len: 3'd4, dashes: 5'b01000};
      5'd7:    p = '{len: 3'd4, dashes: 5'b00011};
      5'd8:    p = '{len: 3'd2, dashes: 5'b00000};
      5'd9:    p = '{len: 3'd4, dashes: 5'b01110};
      5'd10:   p = '{len: 3'd3, dashes: 5'b00101};
      5'd11:   p = '{len: 3'd4, dashes: 5'b00010};
      5'd12:   p = '{len: 3'd2, dashes: 5'b00011};
      5'd13:   p = '{len: 3'd2, dashes: 5'b00001};
      5'd14:   p = '{len: 3'd3, dashes: 5'b00111};
      5'd15:   p = '{len: 3'd4, dashes: 5'b00110};
      5'd16:   p = '{len: 3'd3, dashes: 5'b00010};
      5'd17:   p = '{len: 3'd3, dashes: 5'b00000};
      5'd18:   p = '{len: 3'd1, dashes: 5'b00001};
      5'd19:   p = '{len: 3'd3, dashes: 5'b00100};
      5'd20:   p = '{len: 3'd4, dashes: 5'b00100};
      5'd21:   p = '{len: 3'd4, dashes: 5'b00000};
      5'd22:   p = '{len: 3'd4, dashes: 5'b00101};
      5'd23:   p = '{len: 3'd4, dashes: 5'b00111};
      5'd24:   p = '{len: 3'd4, dashes: 5'b01111};
      5'd25:   p = '{len: 3'd4, dashes: 5'b01011};
      5'd26:   p = '{len: 3'd5, dashes: 5'b11011};
      5'd27:   p = '{len: 3'd4, dashes: 5'b01101};
      5'd28:   p = '{len: 3'd4, dashes: 5'b01001};
      5'd29:   p = '{len: 3'd5, dashes: 5'b00100};
      5'd30:   p = '{len: 3'd4, dashes: 5'b01100};
      5'd31:   p = '{len: 3'd4, dashes: 5'b01010};
      default: p = '{len: 3'd1, dashes: 5'b00000};
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: src/cyrillic_morse_encoder.sv
// ----------------------------------------------------------------------------
// cyrillic_morse_encoder
// Russian Morse encoder: UTF-16 characters in, dot/dash/space/slash out.
// ----------------------------------------------------------------------------
// Each request on the input is one UTF-16 code unit; a Cyrillic letter (either
// case, YO included) becomes its dots and dashes, preceded by a space symbol
// when the message already has symbols and the last thing sent was not a word
// gap; a space character after symbols becomes space, slash, space once per
// run of spaces; anything else sends nothing, and message_start clears the
// message state first. The output carries one symbol per cycle while
// out_ready allows, with last marking the final symbol of a character, so a
// character yields 0 to 6 symbols from the back-end serializer. The front
// end classifies one character per cycle and hands requests through a
// FIFO_DEPTH-entry queue, so input is taken every cycle while it has room.
// ----------------------------------------------------------------------------
`default_nettype none

module cyrillic_morse_encoder #(
  parameter int FIFO_DEPTH = cme_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] char_code,
  input  wire logic        message_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       symbol,
  output logic             last
);
  import cme_pkg::*;

  logic push, full, pop, not_empty;
  job_t push_data, head;

  // front end: classify and build requests
  cme_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_code     (char_code),
    .message_start (message_start),
    .full          (full),
    .push          (push),
    .push_data     (push_data)
  );

  // request queue
  cme_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  // back end: symbol serializer
  cme_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .symbol    (symbol),
    .last      (last)
  );

endmodule

`default_nettype wire

FILE: src/cme_front.sv
// ----------------------------------------------------------------------------
// cme_front
// Accepts characters, tracks message state and queues the symbols to send.
// ----------------------------------------------------------------------------
`default_nettype none

module cme_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [15:0]    char_code,
  input  wire logic           message_start,
  input  wire logic           full,
  output logic                push,
  output cme_pkg::job_t       push_data
);
  import cme_pkg::*;

  logic           has_output, has_output_next;
  logic           gap_just_sent, gap_just_sent_next;
  logic           eff_has, eff_gap, lead_space;
  logic           is_space, is_letter, is_yo;
  pattern_t       pat;
  logic [2*PAT_MAX-1:0] pat_syms;
  logic           accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // classify the character
  always_comb begin
    is_space  = (char_code == CH_SPACE);
    is_yo     = (char_code == CH_YO_UPPER) || (char_code == CH_YO_LOWER);
    is_letter = (char_code >= CH_LETTER_LO) && (char_code <= CH_LETTER_HI);
    pat       = is_yo ? letter_pattern(5'd5) : letter_pattern(char_code[4:0] ^ 5'h10);
    for (int i = 0; i < PAT_MAX; i++) begin
      pat_syms[2*i +: 2] = pat.dashes[i] ? SYM_DASH : SYM_DOT;
    end
  end

  // state after an optional message start, and the request to queue
  always_comb begin
    eff_has            = has_output && !message_start;
    eff_gap            = gap_just_sent && !message_start;
    lead_space         = eff_has && !eff_gap;
    has_output_next    = eff_has;
    gap_just_sent_next = eff_gap;
    push_data.syms     = '0;
    push_data.count    = '0;
    if (is_space) begin
      if (lead_space) begin
        push_data.syms     = {{(SYMS_W-6){1'b0}}, SYM_SPACE, SYM_SLASH, SYM_SPACE};
        push_data.count    = CNT_W'(3);
        gap_just_sent_next = 1'b1;
      end
    end else if (is_letter || is_yo) begin
      has_output_next    = 1'b1;
      gap_just_sent_next = 1'b0;
      if (lead_space) begin
        push_data.syms  = {pat_syms, SYM_SPACE};
        push_data.count = CNT_W'(pat.len) + CNT_W'(1);
      end else begin
        push_data.syms  = {2'b00, pat_syms};
        push_data.count = CNT_W'(pat.len);
      end
    end
    push = accept && (push_data.count != '0);
  end

  // message state
  always_ff @(posedge clk) begin
    if (rst) begin
      has_output    <= 1'b0;
      gap_just_sent <= 1'b0;
    end else if (accept) begin
      has_output    <= has_output_next;
      gap_just_sent <= gap_just_sent_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/cme_fifo.sv
// ----------------------------------------------------------------------------
// cme_fifo
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module cme_fifo #(
  parameter int DEPTH = cme_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cme_pkg::job_t push_data,
  output logic               full,
  input  wire logic          pop,
  output cme_pkg::job_t      head,
  output logic               not_empty
);
  import cme_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QCNT_W = $clog2(DEPTH + 1);

  job_t              entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full      = (fill == QCNT_W'(DEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from empty queue");
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill <= QCNT_W'(DEPTH))
    else $error("queue fill count out of range");
`endif

endmodule

`default_nettype wire

FILE: src/cme_back.sv
// ----------------------------------------------------------------------------
// cme_back
// Takes queued requests and sends their symbols one per cycle while out_ready allows.
// ----------------------------------------------------------------------------
`default_nettype none

module cme_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cme_pkg::job_t head,
  input  wire logic          not_empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         symbol,
  output logic               last
);
  import cme_pkg::*;

  logic [CNT_W-1:0]  rem;
  logic [SYMS_W-1:0] syms;
  logic              advance;

  assign advance = !out_valid || out_ready;
  assign pop     = advance && (rem == '0) && not_empty;

  // output valid and symbols left in the current request
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rem       <= '0;
    end else if (advance) begin
      if (rem != '0) begin
        out_valid <= 1'b1;
        rem       <= rem - CNT_W'(1);
      end else if (not_empty) begin
        out_valid <= 1'b1;
        rem       <= head.count - CNT_W'(1);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // symbol shifter and output register
  always_ff @(posedge clk) begin
    if (advance) begin
      if (rem != '0) begin
        symbol <= syms[1:0];
        last   <= (rem == CNT_W'(1));
        syms   <= syms >> 2;
      end else if (not_empty) begin
        symbol <= head.syms[1:0];
        last   <= (head.count == CNT_W'(1));
        syms   <= head.syms >> 2;
      end
    end
  end

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk) disable iff (rst) rem < CNT_W'(MAX_SYMS))
    else $error("remaining symbol count out of range");
  a_no_empty_request: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.count != '0)
    else $error("empty request in queue");
  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    advance && rem == CNT_W'(1) |=> out_valid && last)
    else $error("final symbol not marked last");
`endif

endmodule

`default_nettype wire
